// File: hw/rtl/acbc_pkg.sv
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, tables and round functions for the AES-128 CBC decryptor.
// ----------------------------------------------------------------------------
package acbc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ROUND_KEY_WORDS = 44;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_IV_HIGH  = 2'd2,
    CFG_IV_LOW   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        first_block;
    logic        last_block;
  } in_word_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  valid_bytes;
    logic        pad_valid;
    logic        final_out;
  } out_word_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] rev_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits 127-8i; byte r+4c is row r, column c
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = rev_sbox(s[127 - 8*(r + 4*c) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127 - 8*(4*c + r) -: 8];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
        m9[r] = x8[r] ^ a[r];
        mb[r] = x8[r] ^ x2[r] ^ a[r];
        md[r] = x8[r] ^ x4[r] ^ a[r];
        me[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] rcon(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return {v, 24'h0};
  endfunction

endpackage

// File: hw/rtl/acbc_stream_if.sv
// ----------------------------------------------------------------------------
// acbc_stream_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface acbc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/acbc_ram.sv
// ----------------------------------------------------------------------------
// acbc_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module acbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hw/rtl/aes128_cbc_decrypt_stream_top.sv
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_stream_top
// AES-128 CBC decryptor with PKCS7 check on the last block of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : ciphertext word (two 64-bit halves, first/last flags).
//   out_if : plaintext word, kept byte count, pad flag, final flag.
//   cfg    : cfg_we_i/cfg_idx_i/cfg_wdata_i write key and IV registers;
//            write only while idle. Values apply at the next first block.
// Round keys live in a 44 x 32 RAM (one port, registered read). A first
// block expands the key, one word written per cycle, words 4..43 built
// from a four-word window held in flops. Decryption reads the round-key
// words one at a time, each as an address step then a data step, and
// after the last key word the CBC-XORed result moves into the output
// register. One word is in flight; in_if.ready is high only while idle.
// While the receiver stalls, the next word is taken and decrypted, then
// waits until the output register frees up, holding off the input. Reset
// clears control state, the chaining value and config registers; the key
// RAM holds nothing until a first block arrives.
// ----------------------------------------------------------------------------
module aes128_cbc_decrypt_stream_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [acbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                  cfg_wdata_i,
  acbc_stream_if.sink                  in_if,
  acbc_stream_if.source                out_if
);
  import acbc_pkg::*;

  localparam int unsigned AddrW = $clog2(ROUND_KEY_WORDS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXP  = 5'b00010,
    ST_RKEY = 5'b00100,
    ST_DONE = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [127:0] chain_q, chain_d, cin_q, work_q, work_d;
  logic last_q;
  logic [31:0] win_q [4];
  logic [AddrW-1:0] kidx_q, kidx_d;
  logic [1:0] col_q, col_d;
  logic [3:0] rnd_q, rnd_d;
  logic rd_pend_q;
  logic out_valid_q;
  out_word_t out_q;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata, exp_word, exp_t;

  logic in_fire;
  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_HIGH: key_hi_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_lo_q <= cfg_wdata_i;
        CFG_IV_HIGH:  iv_hi_q  <= cfg_wdata_i;
        CFG_IV_LOW:   iv_lo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // key expansion word for index kidx_q (>= 4)
  always_comb begin
    exp_t = win_q[3];
    if (kidx_q[1:0] == 2'd0) begin
      exp_t = {fwd_sbox(win_q[3][23:16]), fwd_sbox(win_q[3][15:8]),
               fwd_sbox(win_q[3][7:0]), fwd_sbox(win_q[3][31:24])}
              ^ rcon(4'(kidx_q >> 2));
    end
    exp_word = win_q[0] ^ exp_t;
  end

  // rounds run from rnd 10 down to 0; key word index = rnd*4 + col
  // words 0..3 are the key itself, taken straight from the window
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = exp_word;
    ram_addr  = AddrW'({rnd_q, col_q});
    if (state_q == ST_EXP) begin
      ram_we   = 1'b1;
      ram_addr = kidx_q;
      if (kidx_q < AddrW'(4)) begin
        ram_wdata = win_q[kidx_q[1:0]];
      end
    end
  end

  acbc_ram #(.Width(32), .Depth(ROUND_KEY_WORDS)) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [127:0] keyed, after_add;
  always_comb begin
    keyed = work_q;
    keyed[127 - 32*col_q -: 32] = work_q[127 - 32*col_q -: 32] ^ ram_rdata;
  end

  // key-add for the column read last cycle; round transform after column 3 (none after round 0)
  always_comb begin
    state_d = state_q;
    kidx_d  = kidx_q;
    col_d   = col_q;
    rnd_d   = rnd_q;
    work_d  = work_q;
    chain_d = chain_q;
    after_add = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          work_d = {in_if.data.cipher_high, in_if.data.cipher_low};
          col_d  = 2'd0;
          rnd_d  = 4'd10;
          if (in_if.data.first_block) begin
            chain_d = {iv_hi_q, iv_lo_q};
            kidx_d  = '0;
            state_d = ST_EXP;
          end else begin
            state_d = ST_RKEY;
          end
        end
      end
      ST_EXP: begin
        kidx_d = kidx_q + AddrW'(1);
        if (kidx_q == AddrW'(ROUND_KEY_WORDS - 1)) begin
          state_d = ST_RKEY;
        end
      end
      ST_RKEY: begin
        if (rd_pend_q) begin
          work_d = keyed;
          col_d  = col_q + 2'd1;
          if (col_q == 2'd3) begin
            if (rnd_q == 4'd0) begin
              state_d = ST_DONE;
            end else begin
              after_add = (rnd_q == 4'd10) ? keyed : inv_mix(keyed);
              work_d = inv_shift_sub(after_add);
              rnd_d  = rnd_q - 4'd1;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          state_d = ST_IDLE;
          chain_d = cin_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // address issued while rd_pend is low, data used the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_RKEY) && (state_d == ST_RKEY) && !rd_pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kidx_q  <= '0;
      col_q   <= '0;
      rnd_q   <= '0;
      chain_q <= '0;
      work_q  <= '0;
    end else begin
      state_q <= state_d;
      kidx_q  <= kidx_d;
      col_q   <= col_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
      work_q  <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cin_q  <= {in_if.data.cipher_high, in_if.data.cipher_low};
      last_q <= in_if.data.last_block;
      if (in_if.data.first_block) begin
        win_q[0] <= key_hi_q[63:32];
        win_q[1] <= key_hi_q[31:0];
        win_q[2] <= key_lo_q[63:32];
        win_q[3] <= key_lo_q[31:0];
      end
    end else if (state_q == ST_EXP && kidx_q >= AddrW'(4)) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= exp_word;
    end
  end

  // padding check on the finished block
  logic [127:0] plain;
  logic [7:0] pad;
  logic pad_ok;
  logic [4:0] kept;
  always_comb begin
    plain  = work_q ^ chain_q;
    pad    = plain[7:0];
    pad_ok = last_q && (pad >= 8'd1) && (pad <= 8'd16);
    for (int j = 0; j < 16; j++) begin
      if ((5'(j) >= 5'd16 - pad[4:0]) && pad_ok && (plain[127 - 8*j -: 8] != pad)) begin
        pad_ok = 1'b0;
      end
    end
    kept = pad_ok ? 5'd16 - pad[4:0] : 5'd16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || out_if.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || out_if.ready)) begin
      out_q.plain_high  <= plain[127:64];
      out_q.plain_low   <= plain[63:0];
      out_q.valid_bytes <= kept;
      out_q.pad_valid   <= pad_ok;
      out_q.final_out   <= last_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_DONE || state_q == ST_IDLE))
    else $error("done state left wrongly");
  a_exp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXP) |-> (kidx_q <= AddrW'(ROUND_KEY_WORDS - 1)))
    else $error("expansion index out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (state_q == ST_IDLE))
    else $error("accept while busy");
  a_rd_pend_rkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_RKEY))
    else $error("key read pending outside rounds");

endmodule
